FILE: hdl/hch_pkg.sv
// -----------------------------------------------------------------------------
// hch_pkg
// Shared types, register map and codes for the health check hysteresis block.
// -----------------------------------------------------------------------------
package hch_pkg;

   localparam int WEIGHT_SCALE_DEF = 16;
   localparam int QUEUE_DEPTH      = 2;
   localparam int CSR_ADDR_W       = 5;
   localparam int CSR_DATA_W       = 32;
   // wide enough for a 9-bit weight times a scale of up to 256
   localparam int PROD_W           = 18;
   localparam logic [12:0] WEIGHT_MAX = 13'd8191;

   // outcome codes; every code from FAIL upward counts as a failure
   localparam logic [1:0] OUTCOME_PASS  = 2'd0;
   localparam logic [1:0] OUTCOME_DRAIN = 2'd1;
   localparam logic [1:0] OUTCOME_FAIL  = 2'd2;

   // event codes
   localparam logic [2:0] EV_NONE        = 3'd0;
   localparam logic [2:0] EV_UP          = 3'd1;
   localparam logic [2:0] EV_DOWN        = 3'd2;
   localparam logic [2:0] EV_DRAIN_START = 3'd3;
   localparam logic [2:0] EV_DRAIN_END   = 3'd4;

   // register indexes (byte address is four times the index)
   localparam logic [2:0] CSR_RISE      = 3'd0;
   localparam logic [2:0] CSR_FALL      = 3'd1;
   localparam logic [2:0] CSR_SLOWSTART = 3'd2;
   localparam logic [2:0] CSR_WEIGHT    = 3'd3;
   localparam logic [2:0] CSR_DRAIN_EN  = 3'd4;
   localparam logic [2:0] CSR_DYNAMIC   = 3'd5;

   typedef struct packed {
      logic [1:0]  outcome;
      logic [31:0] now_seconds;
   } req_type;

   typedef struct packed {
      logic        server_up;
      logic        going_down;
      logic        warming_up;
      logic [8:0]  health_level;
      logic [2:0]  event_code;
      logic [12:0] weight_out;
      logic [31:0] fail_total;
      logic [31:0] down_events;
      logic [31:0] down_seconds;
   } rsp_type;

   typedef struct packed {
      logic [7:0]  rise_count;
      logic [7:0]  fall_count;
      logic [15:0] slowstart_seconds;
      logic [8:0]  user_weight;
      logic        drain_enable;
      logic        dynamic_weight;
   } cfg_type;

   // classified check, as queued between front and back
   typedef struct packed {
      logic        is_fail;
      logic        drain_req;
      logic [31:0] now_seconds;
   } cmd_type;

endpackage

FILE: hdl/health_check_hysteresis.sv
// -----------------------------------------------------------------------------
// health_check_hysteresis
// Rise/fall health check counter for one server with drain and slow-start
// weight ramp.
//
//   channel   ports                       role
//   req       req_valid/req_stall/req_data  check outcome and time, in
//   rsp       rsp_valid/rsp_stall/rsp_data  server status after the check, out
//   csr       psel/penable/pwrite/paddr...  register write and read
//
// A check passes through pop, prep and apply before its result shows; a pass
// during a dynamic slow-start ramp also runs the one-bit-per-cycle ceiling
// divider and the weight multiply between prep and apply.
// Reset clears the server state (server down, counter and weight zero) and loads the register defaults.
// A two-entry queue keeps accepting checks until it is full while a result waits on rsp_stall.
// -----------------------------------------------------------------------------
module health_check_hysteresis #(
   parameter int WEIGHT_SCALE = hch_pkg::WEIGHT_SCALE_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  hch_pkg::req_type                 req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output hch_pkg::rsp_type                 rsp_data,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [hch_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [hch_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [hch_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                             pready
);
   import hch_pkg::*;

   cfg_type    cfg_ff;
   logic [2:0] reg_idx;
   logic       wr_en;
   logic       q_full, q_empty, q_push, q_pop;
   cmd_type    push_cmd, pop_cmd;

   assign pready  = 1'b1;
   assign reg_idx = paddr[4:2];
   assign wr_en   = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.rise_count        <= 8'd2;
         cfg_ff.fall_count        <= 8'd3;
         cfg_ff.slowstart_seconds <= 16'd0;
         cfg_ff.user_weight       <= 9'd1;
         cfg_ff.drain_enable      <= 1'b0;
         cfg_ff.dynamic_weight    <= 1'b0;
      end else if (wr_en) begin
         unique case (reg_idx)
            CSR_RISE:      cfg_ff.rise_count        <= pwdata[7:0];
            CSR_FALL:      cfg_ff.fall_count        <= pwdata[7:0];
            CSR_SLOWSTART: cfg_ff.slowstart_seconds <= pwdata[15:0];
            CSR_WEIGHT:    cfg_ff.user_weight       <= pwdata[8:0];
            CSR_DRAIN_EN:  cfg_ff.drain_enable      <= pwdata[0];
            CSR_DYNAMIC:   cfg_ff.dynamic_weight    <= pwdata[0];
            default: begin
               // drop writes past the register map
            end
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         CSR_RISE:      prdata = {24'd0, cfg_ff.rise_count};
         CSR_FALL:      prdata = {24'd0, cfg_ff.fall_count};
         CSR_SLOWSTART: prdata = {16'd0, cfg_ff.slowstart_seconds};
         CSR_WEIGHT:    prdata = {23'd0, cfg_ff.user_weight};
         CSR_DRAIN_EN:  prdata = {31'd0, cfg_ff.drain_enable};
         CSR_DYNAMIC:   prdata = {31'd0, cfg_ff.dynamic_weight};
         default:       prdata = '0;
      endcase
   end

   hch_front u_front (
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_data    (push_cmd)
   );

   hch_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (push_cmd),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (pop_cmd),
      .empty     (q_empty)
   );

   hch_back #(
      .WEIGHT_SCALE (WEIGHT_SCALE)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .q_empty   (q_empty),
      .q_pop     (q_pop),
      .q_data    (pop_cmd),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

FILE: hdl/hch_front.sv
// -----------------------------------------------------------------------------
// hch_front
// Accepts check beats and classifies each outcome into a queued command.
// -----------------------------------------------------------------------------
module hch_front (
   input  logic             req_valid,
   output logic             req_stall,
   input  hch_pkg::req_type req_data,
   input  logic             q_full,
   output logic             q_push,
   output hch_pkg::cmd_type q_data
);
   import hch_pkg::*;

   assign req_stall = q_full;
   assign q_push    = req_valid && !q_full;

   always_comb begin
      q_data.is_fail     = (req_data.outcome >= OUTCOME_FAIL);
      q_data.drain_req   = (req_data.outcome == OUTCOME_DRAIN);
      q_data.now_seconds = req_data.now_seconds;
   end

endmodule

FILE: hdl/hch_queue.sv
// -----------------------------------------------------------------------------
// hch_queue
// Short command queue between the front and the back.
// -----------------------------------------------------------------------------
module hch_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  hch_pkg::cmd_type push_data,
   output logic             full,
   input  logic             pop,
   output hch_pkg::cmd_type pop_data,
   output logic             empty
);
   import hch_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   cmd_type           entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              do_push, do_pop;

   assign full     = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: hdl/hch_back.sv
// -----------------------------------------------------------------------------
// hch_back
// Runs one check against the hysteresis state: ramp divider, weight multiply,
// state update and result register.
// -----------------------------------------------------------------------------
module hch_back #(
   parameter int WEIGHT_SCALE = hch_pkg::WEIGHT_SCALE_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  hch_pkg::cfg_type cfg,
   input  logic             q_empty,
   output logic             q_pop,
   input  hch_pkg::cmd_type q_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output hch_pkg::rsp_type rsp_data
);
   import hch_pkg::*;

   localparam int SCALE_W = $clog2(WEIGHT_SCALE + 1);
   localparam int NUM_MAX = (WEIGHT_SCALE + 1) * 65535 - 1;
   localparam int NUM_W   = $clog2(NUM_MAX + 1);
   localparam int CNT_W   = $clog2(NUM_W);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_PREP  = 3'd1;
   localparam logic [2:0] ST_DIV   = 3'd2;
   localparam logic [2:0] ST_MUL   = 3'd3;
   localparam logic [2:0] ST_APPLY = 3'd4;

   logic [2:0]        state_ff, state_in;
   cmd_type           cmd_ff;
   logic              need_div_ff, warm_end_ff;
   logic [NUM_W-1:0]  num_ff, num_in;
   logic [15:0]       rem_ff, rem_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [12:0]       ramp_w_ff;

   // architectural state
   logic [8:0]  health_ff;
   logic        up_ff, drain_ff, warm_ff;
   logic [31:0] last_ff;
   logic [12:0] eff_ff;
   logic [31:0] failed_ff, downs_ff, dtime_ff;

   logic        rsp_valid_ff;
   rsp_type     rsp_data_ff;

   // prep
   logic        in_window;
   logic [15:0] elapsed;
   logic [NUM_W-1:0] num_start;
   // divider
   logic [16:0] shift_val;
   logic        div_ge;
   // weights
   logic [PROD_W-1:0] ramp_prod, full_prod;
   logic [12:0]       full_w;
   // apply
   logic [8:0]  rise9, sum9, top9, h_inc;
   logic        out_free, commit;
   logic [8:0]  h_n;
   logic        up_n, drain_n, warm_n;
   logic [31:0] last_n, failed_n, downs_n, dtime_n;
   logic [12:0] eff_n;
   logic [2:0]  ev;

   assign q_pop     = (state_ff == ST_IDLE) && !q_empty;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign commit    = (state_ff == ST_APPLY) && out_free;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // warm-up window test: last <= now < last + slowstart
   assign in_window = (cmd_ff.now_seconds >= last_ff) &&
                      ({1'b0, cmd_ff.now_seconds} <
                       ({1'b0, last_ff} + {17'd0, cfg.slowstart_seconds}));
   // inside the window the elapsed time is below 2^16
   assign elapsed   = cmd_ff.now_seconds[15:0] - last_ff[15:0];
   // ceiling numerator: scale * elapsed + slowstart - 1
   assign num_start = NUM_W'(WEIGHT_SCALE) * NUM_W'(elapsed)
                    + NUM_W'(cfg.slowstart_seconds) - NUM_W'(1);

   assign shift_val = {rem_ff, num_ff[NUM_W-1]};
   assign div_ge    = (shift_val >= {1'b0, cfg.slowstart_seconds});

   assign ramp_prod = PROD_W'(num_ff[SCALE_W-1:0]) * PROD_W'(cfg.user_weight);
   assign full_prod = PROD_W'(cfg.user_weight) * PROD_W'(WEIGHT_SCALE);
   assign full_w    = (full_prod > PROD_W'(WEIGHT_MAX)) ? WEIGHT_MAX : full_prod[12:0];

   assign rise9 = {1'b0, cfg.rise_count};
   assign sum9  = {1'b0, cfg.rise_count} + {1'b0, cfg.fall_count};
   assign top9  = (sum9 == '0) ? '0 : sum9 - 9'd1;
   assign h_inc = health_ff + 9'd1;

   // sequencer and divider
   always_comb begin
      state_in = state_ff;
      num_in   = num_ff;
      rem_in   = rem_ff;
      cnt_in   = cnt_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            num_in = num_start;
            rem_in = '0;
            cnt_in = CNT_W'(NUM_W - 1);
            if (!cmd_ff.is_fail && warm_ff && cfg.dynamic_weight && in_window) begin
               state_in = ST_DIV;
            end else begin
               state_in = ST_APPLY;
            end
         end
         ST_DIV: begin
            rem_in = div_ge ? 16'(shift_val - {1'b0, cfg.slowstart_seconds})
                            : shift_val[15:0];
            num_in = {num_ff[NUM_W-2:0], div_ge};
            cnt_in = cnt_ff - CNT_W'(1);
            if (cnt_ff == '0) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            state_in = ST_APPLY;
         end
         ST_APPLY: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state update for one check
   always_comb begin
      h_n      = health_ff;
      up_n     = up_ff;
      drain_n  = drain_ff;
      warm_n   = warm_ff;
      last_n   = last_ff;
      eff_n    = eff_ff;
      failed_n = failed_ff;
      downs_n  = downs_ff;
      dtime_n  = dtime_ff;
      ev       = EV_NONE;
      if (cmd_ff.is_fail) begin
         if (health_ff > rise9) begin
            h_n      = health_ff - 9'd1;
            failed_n = failed_ff + 32'd1;
         end else begin
            if (health_ff == rise9) begin
               last_n  = cmd_ff.now_seconds;
               up_n    = 1'b0;
               drain_n = 1'b0;
               downs_n = downs_ff + 32'd1;
               ev      = EV_DOWN;
            end
            h_n = '0;
         end
      end else begin
         if (need_div_ff) begin
            eff_n = ramp_w_ff;
         end else if (warm_end_ff) begin
            warm_n = 1'b0;
            if (cfg.dynamic_weight) begin
               eff_n = full_w;
            end
         end
         if (up_ff && cfg.drain_enable) begin
            if (drain_ff && !cmd_ff.drain_req) begin
               drain_n = 1'b0;
               ev      = EV_DRAIN_END;
            end else if (!drain_ff && cmd_ff.drain_req) begin
               drain_n = 1'b1;
               ev      = EV_DRAIN_START;
            end
         end
         if (health_ff < top9) begin
            if (h_inc == rise9) begin
               if (last_ff < cmd_ff.now_seconds) begin
                  dtime_n = dtime_ff + (cmd_ff.now_seconds - last_ff);
               end
               last_n = cmd_ff.now_seconds;
               up_n   = 1'b1;
               if (cfg.slowstart_seconds != '0) begin
                  warm_n = 1'b1;
                  if (cfg.dynamic_weight) begin
                     eff_n = {4'd0, cfg.user_weight};
                  end
               end
               ev = EV_UP;
            end
            h_n = (h_inc >= rise9) ? top9 : h_inc;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         health_ff    <= '0;
         up_ff        <= 1'b0;
         drain_ff     <= 1'b0;
         warm_ff      <= 1'b0;
         last_ff      <= '0;
         eff_ff       <= '0;
         failed_ff    <= '0;
         downs_ff     <= '0;
         dtime_ff     <= '0;
      end else begin
         state_ff <= state_in;
         if (commit) begin
            rsp_valid_ff <= 1'b1;
            health_ff    <= h_n;
            up_ff        <= up_n;
            drain_ff     <= drain_n;
            warm_ff      <= warm_n;
            last_ff      <= last_n;
            eff_ff       <= eff_n;
            failed_ff    <= failed_n;
            downs_ff     <= downs_n;
            dtime_ff     <= dtime_n;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         cmd_ff <= q_data;
      end
      if (state_ff == ST_PREP) begin
         need_div_ff <= !cmd_ff.is_fail && warm_ff && cfg.dynamic_weight && in_window;
         warm_end_ff <= !cmd_ff.is_fail && warm_ff && !in_window;
      end
      num_ff <= num_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
      if (state_ff == ST_MUL) begin
         // saturate the ramped weight
         ramp_w_ff <= (ramp_prod > PROD_W'(WEIGHT_MAX)) ? WEIGHT_MAX : ramp_prod[12:0];
      end
      if (commit) begin
         rsp_data_ff.server_up    <= up_n;
         rsp_data_ff.going_down   <= drain_n;
         rsp_data_ff.warming_up   <= warm_n;
         rsp_data_ff.health_level <= h_n;
         rsp_data_ff.event_code   <= ev;
         rsp_data_ff.weight_out   <= eff_n;
         rsp_data_ff.fail_total   <= failed_n;
         rsp_data_ff.down_events  <= downs_n;
         rsp_data_ff.down_seconds <= dtime_n;
      end
   end

   a_drain_needs_up: assert property (@(posedge clock) disable iff (reset)
      !up_ff |-> !drain_ff)
      else $error("going_down set while server is down");

   a_up_event: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_data_ff.event_code == EV_UP) |-> rsp_data_ff.server_up)
      else $error("up event reported with server down");

   a_down_event: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_data_ff.event_code == EV_DOWN)
      |-> !rsp_data_ff.server_up && !rsp_data_ff.going_down)
      else $error("down event reported with server still up or draining");

   a_mul_after_div: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MUL) |-> ($past(state_ff) == ST_DIV))
      else $error("weight multiply entered without a division");

   a_commit_once: assert property (@(posedge clock) disable iff (reset)
      commit |=> (state_ff == ST_IDLE))
      else $error("sequencer did not return to idle after commit");

endmodule

FILE: test/health_check_hysteresis_test.sv
// -----------------------------------------------------------------------------
// health_check_hysteresis_test
// Self-checking bench for the rise/fall health check block. A queue of checks
// feeds a clocked driver; a clocked monitor compares every status beat with a
// status predicted from a local copy of the counter, flags and registers.
// Phases with different register settings and idle patterns follow a short
// directed sequence.
// -----------------------------------------------------------------------------
module health_check_hysteresis_test;
   import hch_pkg::*;

   localparam int SCALE        = WEIGHT_SCALE_DEF;
   localparam int CYCLE_LIMIT  = 500000;
   localparam int SETTLE_CYCLES = 40;
   // the top outcome code also counts as a failure
   localparam logic [1:0] OUTCOME_FAIL_ALT = 2'd3;

   typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_STALL, IDLE_BOTH} idle_mode_e;

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   req_type               req_data  = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rsp_type               rsp_data;
   logic                  psel      = 1'b0;
   logic                  penable   = 1'b0;
   logic                  pwrite    = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr     = '0;
   logic [CSR_DATA_W-1:0] pwdata    = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   health_check_hysteresis #(.WEIGHT_SCALE(SCALE)) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   // register copy and server state as the block should hold them
   cfg_type     cfg_now;
   logic [8:0]  health;
   logic        up_flag;
   logic        drain_flag;
   logic        warm_flag;
   logic [31:0] stamp_secs;
   logic [12:0] eff_weight;
   logic [31:0] fail_cnt;
   logic [31:0] down_cnt;
   logic [31:0] down_secs;

   req_type check_q[$];
   rsp_type status_q[$];

   int          checks_queued = 0;
   int          checks_sent   = 0;
   int          results_seen  = 0;
   int          errors        = 0;
   int          settings      = 0;
   int          cycles        = 0;
   int          send_idle_pct = 0;
   int          stall_pct     = 0;
   int          event_seen[5];
   logic [31:0] clock_secs    = '0;

   initial begin
      forever #1 clock = ~clock;
   end

   function automatic logic [12:0] clip_weight(input logic [63:0] w);
      return (w > WEIGHT_MAX) ? WEIGHT_MAX : w[12:0];
   endfunction

   // advance the server state by one check and queue the status it leaves
   task automatic predict_status(input req_type chk);
      rsp_type     st;
      logic [2:0]  ev;
      logic [9:0]  span;
      logic [8:0]  top;
      logic [32:0] warm_end;
      logic [63:0] elapsed;
      logic [63:0] ramp;
      logic [31:0] now;
      begin
         ev   = EV_NONE;
         now  = chk.now_seconds;
         span = {2'd0, cfg_now.rise_count} + {2'd0, cfg_now.fall_count};
         top  = (span == 10'd0) ? 9'd0 : 9'(span - 10'd1);
         if (chk.outcome >= OUTCOME_FAIL) begin
            if (health > {1'b0, cfg_now.rise_count}) begin
               health   = health - 9'd1;
               fail_cnt = fail_cnt + 32'd1;
            end else begin
               if (health == {1'b0, cfg_now.rise_count}) begin
                  stamp_secs  = now;
                  up_flag     = 1'b0;
                  drain_flag  = 1'b0;
                  down_cnt    = down_cnt + 32'd1;
                  ev          = EV_DOWN;
               end
               health = '0;
            end
         end else begin
            if (warm_flag) begin
               warm_end = {1'b0, stamp_secs};
               warm_end = warm_end + {17'd0, cfg_now.slowstart_seconds};
               if (now < stamp_secs || {1'b0, now} >= warm_end) begin
                  warm_flag = 1'b0;
                  if (cfg_now.dynamic_weight)
                     eff_weight = clip_weight(cfg_now.user_weight * SCALE);
               end else if (cfg_now.dynamic_weight) begin
                  // elapsed is below the warm-up length, so the divisor is nonzero
                  elapsed    = {32'd0, now - stamp_secs};
                  ramp       = (SCALE * elapsed + cfg_now.slowstart_seconds - 1)
                               / cfg_now.slowstart_seconds;
                  eff_weight = clip_weight(ramp * cfg_now.user_weight);
               end
            end
            if (up_flag && cfg_now.drain_enable) begin
               if (drain_flag && chk.outcome == OUTCOME_PASS) begin
                  drain_flag = 1'b0;
                  ev         = EV_DRAIN_END;
               end else if (!drain_flag && chk.outcome == OUTCOME_DRAIN) begin
                  drain_flag = 1'b1;
                  ev         = EV_DRAIN_START;
               end
            end
            if (health < top) begin
               health = health + 9'd1;
               if (health == {1'b0, cfg_now.rise_count}) begin
                  if (stamp_secs < now)
                     down_secs = down_secs + (now - stamp_secs);
                  stamp_secs  = now;
                  up_flag     = 1'b1;
                  if (cfg_now.slowstart_seconds > 0) begin
                     warm_flag = 1'b1;
                     if (cfg_now.dynamic_weight)
                        eff_weight = {4'd0, cfg_now.user_weight};
                  end
                  ev = EV_UP;
               end
               if (health >= {1'b0, cfg_now.rise_count})
                  health = top;
            end
         end
         st.server_up    = up_flag;
         st.going_down   = drain_flag;
         st.warming_up   = warm_flag;
         st.health_level = health;
         st.event_code   = ev;
         st.weight_out   = eff_weight;
         st.fail_total   = fail_cnt;
         st.down_events  = down_cnt;
         st.down_seconds = down_secs;
         status_q.push_back(st);
      end
   endtask

   // driver: hold each beat until accepted, then predict and pick the next
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (req_valid) begin
            predict_status(req_data);
            checks_sent = checks_sent + 1;
         end
         if (check_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_data  <= check_q.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      begin
         if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            errors = errors + 1;
         end
      end
   endtask

   // monitor: compare each accepted status beat with the oldest prediction
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
         if (rsp_valid && !rsp_stall) begin
            results_seen = results_seen + 1;
            if (status_q.size() == 0) begin
               $display("%0t: status beat with none expected, actual %h", $time, rsp_data);
               errors = errors + 1;
            end else begin
               want = status_q.pop_front();
               check_field("server_up",    32'(want.server_up),    32'(rsp_data.server_up));
               check_field("going_down",   32'(want.going_down),   32'(rsp_data.going_down));
               check_field("warming_up",   32'(want.warming_up),   32'(rsp_data.warming_up));
               check_field("health_level", 32'(want.health_level),
                           32'(rsp_data.health_level));
               check_field("event_code",   32'(want.event_code),   32'(rsp_data.event_code));
               check_field("weight_out",   32'(want.weight_out),   32'(rsp_data.weight_out));
               check_field("fail_total",   want.fail_total,   rsp_data.fail_total);
               check_field("down_events",  want.down_events,  rsp_data.down_events);
               check_field("down_seconds", want.down_seconds, rsp_data.down_seconds);
               if (want.event_code <= EV_DRAIN_END)
                  event_seen[want.event_code] = event_seen[want.event_code] + 1;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles = cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d status beats outstanding", $time, status_q.size());
         $display("Verification failed");
         $finish;
      end
   end

   // write one register, then read it back
   task automatic csr_access(input logic [2:0] idx, input logic [31:0] value);
      begin
         @(posedge clock);
         psel    <= 1'b1;
         penable <= 1'b0;
         pwrite  <= 1'b1;
         paddr   <= {idx, 2'b00};
         pwdata  <= value;
         @(posedge clock);
         penable <= 1'b1;
         do @(posedge clock); while (!pready);
         case (idx)
            CSR_RISE:      cfg_now.rise_count        = value[7:0];
            CSR_FALL:      cfg_now.fall_count        = value[7:0];
            CSR_SLOWSTART: cfg_now.slowstart_seconds = value[15:0];
            CSR_WEIGHT:    cfg_now.user_weight       = value[8:0];
            CSR_DRAIN_EN:  cfg_now.drain_enable      = value[0];
            CSR_DYNAMIC:   cfg_now.dynamic_weight    = value[0];
            default: ;
         endcase
         pwrite  <= 1'b0;
         penable <= 1'b0;
         @(posedge clock);
         penable <= 1'b1;
         do @(posedge clock); while (!pready);
         if (prdata !== value) begin
            $display("%0t: register %0d readback, expected %0h, actual %0h",
                     $time, idx, value, prdata);
            errors = errors + 1;
         end
         psel    <= 1'b0;
         penable <= 1'b0;
      end
   endtask

   task automatic wait_quiet();
      begin
         while (results_seen < checks_queued) @(posedge clock);
      end
   endtask

   // reprogram all registers once the block is quiet, then set the idle pattern
   task automatic set_phase(input int rise, input int fall, input int ss,
                            input int weight, input int drain_en, input int dyn,
                            input idle_mode_e mode);
      begin
         wait_quiet();
         csr_access(CSR_RISE, rise);
         csr_access(CSR_FALL, fall);
         csr_access(CSR_SLOWSTART, ss);
         csr_access(CSR_WEIGHT, weight);
         csr_access(CSR_DRAIN_EN, drain_en);
         csr_access(CSR_DYNAMIC, dyn);
         send_idle_pct = (mode == IDLE_SEND) ? 84 : (mode == IDLE_BOTH) ? 16 : 0;
         stall_pct     = (mode == IDLE_STALL) ? 84 : (mode == IDLE_BOTH) ? 16 : 0;
         settings      = settings + 1;
      end
   endtask

   task automatic queue_check(input logic [1:0] outcome, input logic [31:0] now);
      req_type chk;
      begin
         chk.outcome     = outcome;
         chk.now_seconds = now;
         check_q.push_back(chk);
         checks_queued = checks_queued + 1;
         clock_secs    = now;
      end
   endtask

   // mostly creep forward inside the warm-up window; sometimes jump or go back
   function automatic logic [31:0] next_secs();
      int r;
      r = $urandom_range(99);
      if (r < 4)
         return $urandom();
      else if (r < 8)
         return clock_secs - $urandom_range(1, 50);
      return clock_secs + $urandom_range(0, cfg_now.slowstart_seconds / 3 + 3);
   endfunction

   // runs of passes and failures long enough to cross the thresholds, plus noise
   task automatic queue_checks(input int count);
      int         n;
      int         len;
      int         kind;
      int         i;
      logic [1:0] outcome;
      begin
         n = 0;
         while (n < count) begin
            kind = $urandom_range(9);
            if (kind <= 3)
               len = $urandom_range(1, cfg_now.rise_count + 1);
            else if (kind <= 6)
               len = $urandom_range(1, cfg_now.fall_count + 1);
            else
               len = $urandom_range(1, 4);
            for (i = 0; i < len && n < count; i++) begin
               if (kind <= 3)
                  outcome = ($urandom_range(3) == 0) ? OUTCOME_DRAIN : OUTCOME_PASS;
               else if (kind <= 6)
                  outcome = ($urandom_range(3) == 0) ? OUTCOME_FAIL_ALT : OUTCOME_FAIL;
               else if (kind == 7)
                  outcome = i[0] ? OUTCOME_PASS : OUTCOME_DRAIN;
               else
                  outcome = 2'($urandom_range(3));
               queue_check(outcome, next_secs());
               n = n + 1;
            end
         end
      end
   endtask

   initial begin
      int p;
      for (p = 0; p < 5; p++) event_seen[p] = 0;
      cfg_now     = '0;
      cfg_now.rise_count  = 8'd2;
      cfg_now.fall_count  = 8'd3;
      cfg_now.user_weight = 9'd1;
      health      = '0;
      up_flag     = 1'b0;
      drain_flag  = 1'b0;
      warm_flag   = 1'b0;
      stamp_secs  = '0;
      eff_weight  = '0;
      fail_cnt    = '0;
      down_cnt    = '0;
      down_secs   = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed: drain while down, rise with ramp, drain toggles, fall,
      // time at the top of the range, warm-up window past wrap, time going back
      set_phase(2, 2, 10, 256, 1, 1, IDLE_NONE);
      queue_check(OUTCOME_DRAIN,    32'd0);
      queue_check(OUTCOME_PASS,     32'd5);
      queue_check(OUTCOME_DRAIN,    32'd7);
      queue_check(OUTCOME_DRAIN,    32'd8);
      queue_check(OUTCOME_PASS,     32'd9);
      queue_check(OUTCOME_PASS,     32'd100);
      queue_check(OUTCOME_FAIL_ALT, 32'd101);
      queue_check(OUTCOME_FAIL,     32'd102);
      queue_check(OUTCOME_FAIL,     32'd103);
      queue_check(OUTCOME_PASS,     32'hFFFF_FFFF);
      queue_check(OUTCOME_PASS,     32'hFFFF_FFFF);
      queue_check(OUTCOME_PASS,     32'hFFFF_FFFF);
      queue_check(OUTCOME_PASS,     32'd3);
      queue_check(OUTCOME_DRAIN,    32'd4);
      queue_check(OUTCOME_FAIL,     32'd5);
      queue_check(OUTCOME_FAIL,     32'd6);
      queue_check(OUTCOME_FAIL,     32'd7);
      queue_check(OUTCOME_PASS,     32'h5555_5555);
      queue_check(OUTCOME_PASS,     32'hAAAA_AAAA);
      queue_check(OUTCOME_DRAIN,    32'hAAAA_AAAB);
      queue_check(OUTCOME_PASS,     32'h8000_0000);
      queue_check(OUTCOME_FAIL_ALT, 32'h7FFF_FFFF);
      queue_check(OUTCOME_FAIL,     32'h0000_0000);

      set_phase(2, 3, 0, 1, 0, 0, IDLE_NONE);
      queue_checks(60);
      set_phase(3, 2, 20, 256, 1, 1, IDLE_SEND);
      queue_checks(70);
      set_phase(1, 1, 65535, 0, 1, 1, IDLE_STALL);
      queue_checks(50);
      set_phase(4, 4, 1, 255, 1, 0, IDLE_BOTH);
      queue_checks(60);
      // raise the rise count while the server may still be up
      set_phase(9, 4, 40, 77, 1, 1, IDLE_SEND);
      queue_checks(40);
      set_phase(255, 255, 7, 128, 1, 1, IDLE_STALL);
      queue_checks(40);
      set_phase(1, 255, 5, 256, 0, 1, IDLE_NONE);
      queue_checks(30);
      for (p = 0; p < 3; p++) begin
         set_phase($urandom_range(1, 8), $urandom_range(1, 8), $urandom_range(0, 60),
                   $urandom_range(0, 256), $urandom_range(1), $urandom_range(1),
                   idle_mode_e'($urandom_range(3)));
         queue_checks(30);
      end

      wait_quiet();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (status_q.size() != 0) begin
         $display("%0t: %0d status beats never arrived", $time, status_q.size());
         errors = errors + 1;
      end
      $display("Ran %0d health checks under %0d register settings, %0d status beats, %0d errors.",
               checks_sent, settings, results_seen, errors);
      $display("Transitions: %0d up, %0d down, %0d drain start, %0d drain end.",
               event_seen[EV_UP], event_seen[EV_DOWN], event_seen[EV_DRAIN_START],
               event_seen[EV_DRAIN_END]);
      if (errors == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

FILE: files.f
hdl/hch_pkg.sv
hdl/hch_front.sv
hdl/hch_queue.sv
hdl/hch_back.sv
hdl/health_check_hysteresis.sv
test/health_check_hysteresis_test.sv
